@@ rtl/dfalex_pkg.sv @@
// ----------------------------------------------------------------------------
// dfalex_pkg
// shared constants and table functions of the longest-match lexer
// ----------------------------------------------------------------------------
package dfalex_pkg;

    localparam int LINE_CHARS_DEF = 1024;
    localparam int MAX_RES        = 4;

    localparam logic [2:0] KIND_ID    = 3'd0;
    localparam logic [2:0] KIND_IF    = 3'd1;
    localparam logic [2:0] KIND_WS    = 3'd2;
    localparam logic [2:0] KIND_ERR   = 3'd3;
    localparam logic [2:0] KIND_REAL  = 3'd4;
    localparam logic [2:0] KIND_NUM   = 3'd5;
    localparam logic [2:0] KIND_CMT   = 3'd6;

    localparam logic [3:0] ST_DEAD  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_ERR   = 4'd13;

    localparam logic [5:0] CL_SPACE = 6'd0;
    localparam logic [5:0] CL_F     = 6'd6;
    localparam logic [5:0] CL_I     = 6'd9;
    localparam logic [5:0] CL_P     = 6'd16;
    localparam logic [5:0] CL_DOT   = 6'd37;
    localparam logic [5:0] CL_DASH  = 6'd38;
    localparam logic [5:0] CL_NL    = 6'd39;
    localparam logic [5:0] CL_OTHER = 6'd40;

    localparam logic [7:0] CHAR_NL = 8'd10;

    function automatic logic [5:0] char_class(input logic [7:0] c);
        logic [5:0] k;
        if (c == 8'd32) k = CL_SPACE;
        else if (c >= 8'd97 && c <= 8'd122) k = 6'(c - 8'd96);
        else if (c >= 8'd48 && c <= 8'd57) k = 6'(c - 8'd47) + 6'd26;
        else if (c == 8'd46) k = CL_DOT;
        else if (c == 8'd45) k = CL_DASH;
        else if (c == CHAR_NL) k = CL_NL;
        else k = CL_OTHER;
        return k;
    endfunction

    function automatic logic [3:0] next_state(input logic [3:0] s, input logic [5:0] k);
        logic letter, digit, btok;
        logic [3:0] n;
        letter = (k >= 6'd1 && k <= 6'd26);
        digit  = (k >= 6'd27 && k <= 6'd36);
        btok   = (k >= 6'd2 && k <= 6'd11);
        n = ST_DEAD;
        case (s)
            4'd1: begin
                if (k == CL_SPACE) n = 4'd12;
                else if (k == CL_I) n = 4'd2;
                else if (letter) n = 4'd4;
                else if (digit) n = 4'd7;
                else if (k == CL_DOT) n = 4'd5;
                else if (k == CL_DASH) n = 4'd9;
                else n = ST_ERR;
            end
            4'd2: begin
                if (k == CL_F) n = 4'd3;
                else if (letter || digit) n = 4'd4;
            end
            4'd3, 4'd4: if (letter || digit) n = 4'd4;
            4'd5: if (k == CL_P || digit) n = 4'd6;
            4'd6: begin
                if (btok) n = 4'd8;
                else if (digit) n = 4'd6;
            end
            4'd7: begin
                if (digit) n = 4'd7;
                else if (k == CL_DOT) n = 4'd8;
            end
            4'd8: if (btok || digit) n = 4'd8;
            4'd9: if (k == CL_DASH) n = 4'd10;
            4'd10: begin
                if (letter) n = 4'd10;
                else if (k == CL_NL) n = 4'd11;
            end
            4'd12: if (k == CL_SPACE) n = 4'd12;
            default: n = ST_DEAD;
        endcase
        return n;
    endfunction

    function automatic logic is_accepting(input logic [3:0] s);
        return (s >= 4'd2 && s <= 4'd9) || (s >= 4'd11 && s <= 4'd13);
    endfunction

    function automatic logic [2:0] kind_of(input logic [3:0] s);
        logic [2:0] r;
        case (s)
            4'd2, 4'd4: r = KIND_ID;
            4'd3:       r = KIND_IF;
            4'd12:      r = KIND_WS;
            4'd6, 4'd8: r = KIND_REAL;
            4'd7:       r = KIND_NUM;
            4'd11:      r = KIND_CMT;
            default:    r = KIND_ERR;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/dfalex_if.sv @@
// ----------------------------------------------------------------------------
// dfalex_in_if / dfalex_out_if
// valid/ready channels of the lexer
// ----------------------------------------------------------------------------
interface dfalex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;
    modport source (output valid, char_code, line_end, input ready);
    modport sink   (input valid, char_code, line_end, output ready);
endinterface

interface dfalex_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [9:0]  token_start;
    logic [10:0] token_length;
    logic        last_of_step;
    modport source (output valid, token_kind, token_start, token_length, last_of_step,
                    input ready);
    modport sink   (input valid, token_kind, token_start, token_length, last_of_step,
                    output ready);
endinterface

@@ rtl/dfa_longest_match_lexer.sv @@
// ----------------------------------------------------------------------------
// dfa_longest_match_lexer
// longest-match lexer of one text line over a fixed 14-state automaton
// ----------------------------------------------------------------------------
// Each input transfer writes one character into the line store and starts a
// small sequencer. The sequencer scans the stored line with one table step per
// character. When the automaton dies it backs up to the last accepting
// position and emits that token. Input is not ready while the sequencer runs
// or while a token waits for output. An item that completes no token passes
// through check, ram read, table step, check and idle before the next transfer
// can happen. Each character that is rescanned after a token passes through
// ram read, table step and check. Each token also passes through the emit
// state, which first moves any held token to the output register, and every
// token also waits for the output handshake. At line end the pending
// characters are flushed the same way. Tokens that begin with a newline are
// dropped. last_of_step marks the final token of an item.
module dfa_longest_match_lexer #(
    parameter int LINE_CHARS = dfalex_pkg::LINE_CHARS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dfalex_in_if.sink    i_in,
    dfalex_out_if.source o_out
);
    import dfalex_pkg::*;

    localparam int AW = $clog2(LINE_CHARS);
    localparam int PW = AW + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_STEP  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_CHK   = 5'b10000
    } t_state;

    t_state r_st, n_st;
    logic [3:0]    r_dfa, n_dfa, r_acc_st, n_acc_st;
    logic [PW-1:0] r_begin, n_begin, r_acc_len, n_acc_len, r_scan, n_scan, r_fill, n_fill;
    logic          r_end, n_end;
    logic          r_first_nl, n_first_nl;
    logic          r_pend, n_pend;       // a token is being held for output
    logic [2:0]    r_kind, n_kind;
    logic [9:0]    r_tstart, n_tstart;
    logic [10:0]   r_tlen, n_tlen;
    logic [2:0]    r_okind, n_okind;
    logic [9:0]    r_ostart, n_ostart;
    logic [10:0]   r_olen, n_olen;
    logic          r_ovalid, n_ovalid;
    logic          r_olast, n_olast;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    logic [3:0]    nx;
    logic [PW-1:0] len, w_idx;
    logic          more;

    dfalex_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_in.char_code),
        .o_rdata(ram_rdata)
    );

    assign i_in.ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_out.valid        = r_ovalid;
    assign o_out.token_kind   = r_okind;
    assign o_out.token_start  = r_ostart;
    assign o_out.token_length = r_olen;
    assign o_out.last_of_step = r_olast;

    assign nx  = next_state(r_dfa, char_class(ram_rdata));
    assign len = (r_acc_len == '0) ? PW'(1) : r_acc_len;
    assign w_idx = (r_fill >= PW'(LINE_CHARS)) ? PW'(LINE_CHARS - 1) : r_fill;

    always_comb begin
        n_st = r_st; n_dfa = r_dfa; n_acc_st = r_acc_st; n_begin = r_begin;
        n_acc_len = r_acc_len; n_scan = r_scan; n_fill = r_fill; n_end = r_end;
        n_first_nl = r_first_nl; n_pend = r_pend; n_kind = r_kind; n_tstart = r_tstart;
        n_tlen = r_tlen; n_ovalid = r_ovalid; n_olast = r_olast;
        n_okind = r_okind; n_ostart = r_ostart; n_olen = r_olen;
        ram_we = 1'b0;
        ram_addr = r_scan[AW-1:0];
        more = 1'b0;
        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;
        case (r_st)
            S_IDLE: begin
                ram_addr = w_idx[AW-1:0];
                if (i_in.valid && i_in.ready) begin
                    ram_we = 1'b1;
                    n_fill = w_idx + PW'(1);
                    n_end = i_in.line_end || (w_idx + PW'(1) >= PW'(LINE_CHARS));
                    if (r_scan == r_begin && w_idx == r_begin) begin
                        n_first_nl = (i_in.char_code == CHAR_NL);
                    end
                    n_st = S_CHK;
                end
            end
            S_CHK: begin
                // decide: scan more, flush, or finish the item
                if (r_scan < r_fill) begin
                    n_st = S_READ;
                end else if (r_end && r_begin < r_fill) begin
                    n_st = S_EMIT;
                end else begin
                    if (r_pend && !r_ovalid) begin
                        n_ovalid = 1'b1; n_olast = 1'b1; n_pend = 1'b0;
                        n_okind = r_kind; n_ostart = r_tstart; n_olen = r_tlen;
                    end
                    if (!r_pend || !r_ovalid) begin
                        if (r_end) begin
                            n_dfa = ST_START; n_begin = '0; n_acc_len = '0;
                            n_acc_st = ST_DEAD; n_scan = '0; n_fill = '0; n_end = 1'b0;
                        end
                        n_st = S_IDLE;
                    end
                end
            end
            S_READ: n_st = S_STEP;
            S_STEP: begin
                if (r_scan == r_begin) n_first_nl = (ram_rdata == CHAR_NL);
                if (nx == ST_DEAD) begin
                    n_st = S_EMIT;
                end else begin
                    n_scan = r_scan + PW'(1);
                    n_dfa = nx;
                    if (is_accepting(nx)) begin
                        n_acc_st = nx;
                        n_acc_len = r_scan + PW'(1) - r_begin;
                    end
                    n_st = S_CHK;
                end
            end
            S_EMIT: begin
                more = !r_first_nl;
                // held token goes out first, as not-last
                if (more && r_pend) begin
                    if (!r_ovalid) begin
                        n_ovalid = 1'b1; n_olast = 1'b0; n_pend = 1'b0;
                        n_okind = r_kind; n_ostart = r_tstart; n_olen = r_tlen;
                    end
                end else begin
                    if (more) begin
                        n_pend = 1'b1;
                        n_kind = kind_of((r_acc_len == '0) ? ST_ERR : r_acc_st);
                        n_tstart = 10'(r_begin);
                        n_tlen = (kind_of((r_acc_len == '0) ? ST_ERR : r_acc_st) == KIND_CMT)
                               ? 11'(len - PW'(1)) : 11'(len);
                    end
                    n_begin = r_begin + len;
                    n_scan = r_begin + len;
                    n_dfa = ST_START; n_acc_len = '0; n_acc_st = ST_DEAD;
                    n_first_nl = 1'b0;
                    n_st = S_CHK;
                    if (r_begin + len < r_fill) begin
                        n_st = S_READ;
                        n_scan = r_begin + len;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_dfa <= ST_START; r_acc_st <= ST_DEAD; r_begin <= '0;
            r_acc_len <= '0; r_scan <= '0; r_fill <= '0; r_end <= 1'b0;
            r_first_nl <= 1'b0; r_pend <= 1'b0; r_ovalid <= 1'b0; r_olast <= 1'b0;
        end else begin
            r_st <= n_st; r_dfa <= n_dfa; r_acc_st <= n_acc_st; r_begin <= n_begin;
            r_acc_len <= n_acc_len; r_scan <= n_scan; r_fill <= n_fill; r_end <= n_end;
            r_first_nl <= n_first_nl; r_pend <= n_pend; r_ovalid <= n_ovalid;
            r_olast <= n_olast;
        end
        r_kind <= n_kind; r_tstart <= n_tstart; r_tlen <= n_tlen;
        r_okind <= n_okind; r_ostart <= n_ostart; r_olen <= n_olen;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_in.ready) else $error("input taken while busy");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= r_fill) else $error("scan ran past fill");
    a_begin_le_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_begin <= r_scan) else $error("token start after scan");
`endif
endmodule

@@ rtl/dfalex_ram.sv @@
// ----------------------------------------------------------------------------
// dfalex_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module dfalex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ sim/dfalex_tb_if.sv @@
// ----------------------------------------------------------------------------
// dfalex_tb_if
// the bench uses the channel interfaces of the rtl build, no local copies
// ----------------------------------------------------------------------------

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of dfa_longest_match_lexer
// ----------------------------------------------------------------------------
// Characters are sent one per transfer with random gaps; a local lexer
// tracks the line and the automaton, predicts the tokens each character
// causes, and a checker compares every token transfer with the oldest
// prediction while the token side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dfalex_pkg::*;

    localparam int LINE_LEN  = 1024;
    localparam int CYCLE_MAX = 1000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  start;
        logic [10:0] length;
        logic        last;
    } t_token;

    logic i_clk;
    logic i_rst_n;
    dfalex_in_if  chr_if ();
    dfalex_out_if tok_if ();

    dfa_longest_match_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chr_if.sink),
        .o_out   (tok_if.source)
    );

    t_token tokens_due[$];
    int     mismatch_cnt;
    int     cycle_cnt;

    // local lexer state
    logic [7:0]  line_buf [LINE_LEN];
    logic [3:0]  lx_state;
    logic [10:0] lx_begin, lx_acc_len, lx_pos, lx_fill;
    logic [3:0]  lx_acc_state;

    function automatic logic [5:0] class_of(logic [7:0] c);
        if (c == 8'd32) return CL_SPACE;
        if (c >= 8'd97 && c <= 8'd122) return 6'(c - 8'd96);
        if (c >= 8'd48 && c <= 8'd57) return 6'(c - 8'd47) + 6'd26;
        if (c == 8'd46) return CL_DOT;
        if (c == 8'd45) return CL_DASH;
        if (c == CHAR_NL) return CL_NL;
        return CL_OTHER;
    endfunction

    function automatic logic [3:0] step_of(logic [3:0] s, logic [5:0] k);
        logic letter, digit, btok;
        letter = (k >= 6'd1 && k <= 6'd26);
        digit  = (k >= 6'd27 && k <= 6'd36);
        btok   = (k >= 6'd2 && k <= 6'd11);
        case (s)
            4'd1: begin
                if (k == CL_SPACE) return 4'd12;
                if (k == CL_I) return 4'd2;
                if (letter) return 4'd4;
                if (digit) return 4'd7;
                if (k == CL_DOT) return 4'd5;
                if (k == CL_DASH) return 4'd9;
                return ST_ERR;
            end
            4'd2: begin
                if (k == CL_F) return 4'd3;
                return (letter || digit) ? 4'd4 : ST_DEAD;
            end
            4'd3, 4'd4: return (letter || digit) ? 4'd4 : ST_DEAD;
            4'd5: return (k == CL_P || digit) ? 4'd6 : ST_DEAD;
            4'd6: begin
                if (btok) return 4'd8;
                return digit ? 4'd6 : ST_DEAD;
            end
            4'd7: begin
                if (digit) return 4'd7;
                return (k == CL_DOT) ? 4'd8 : ST_DEAD;
            end
            4'd8: return (btok || digit) ? 4'd8 : ST_DEAD;
            4'd9: return (k == CL_DASH) ? 4'd10 : ST_DEAD;
            4'd10: begin
                if (letter) return 4'd10;
                return (k == CL_NL) ? 4'd11 : ST_DEAD;
            end
            4'd12: return (k == CL_SPACE) ? 4'd12 : ST_DEAD;
            default: return ST_DEAD;
        endcase
    endfunction

    function automatic logic [2:0] token_kind_of(logic [3:0] s);
        case (s)
            4'd2, 4'd4: return KIND_ID;
            4'd3:       return KIND_IF;
            4'd12:      return KIND_WS;
            4'd6, 4'd8: return KIND_REAL;
            4'd7:       return KIND_NUM;
            4'd11:      return KIND_CMT;
            default:    return KIND_ERR;
        endcase
    endfunction

    function automatic logic accepts(logic [3:0] s);
        return (s >= 4'd2 && s <= 4'd9) || (s >= 4'd11 && s <= 4'd13);
    endfunction

    task automatic cut_token(inout t_token found[$]);
        logic [10:0] len;
        logic [3:0]  st;
        t_token      t;
        len = lx_acc_len;
        st  = lx_acc_state;
        if (len == 11'd0) begin
            len = 11'd1;
            st  = ST_ERR;
        end
        if (lx_begin < LINE_LEN && line_buf[lx_begin] != CHAR_NL) begin
            t.kind   = token_kind_of(st);
            t.start  = lx_begin[9:0];
            t.length = (t.kind == KIND_CMT) ? len - 11'd1 : len;
            t.last   = 1'b0;
            if (found.size() < MAX_RES) found.push_back(t);
        end
        lx_begin     = lx_begin + len;
        lx_pos       = lx_begin;
        lx_state     = ST_START;
        lx_acc_len   = '0;
        lx_acc_state = ST_DEAD;
    endtask

    task automatic lex_char(logic [7:0] c, logic eol);
        t_token      found[$];
        logic [3:0]  nx;
        logic        fin;
        fin = eol;
        if (lx_fill >= LINE_LEN) lx_fill = 11'(LINE_LEN - 1);
        line_buf[lx_fill] = c;
        lx_fill = lx_fill + 11'd1;
        if (lx_fill >= LINE_LEN) fin = 1'b1;
        forever begin
            while (lx_pos < lx_fill && lx_pos < LINE_LEN) begin
                nx = step_of(lx_state, class_of(line_buf[lx_pos]));
                if (nx == ST_DEAD) begin
                    cut_token(found);
                end else begin
                    lx_pos   = lx_pos + 11'd1;
                    lx_state = nx;
                    if (accepts(nx)) begin
                        lx_acc_state = nx;
                        lx_acc_len   = lx_pos - lx_begin;
                    end
                end
            end
            if (!fin || lx_begin >= lx_fill) break;
            cut_token(found);
        end
        if (fin) begin
            lx_state = ST_START;
            lx_begin = '0; lx_acc_len = '0; lx_acc_state = ST_DEAD; lx_pos = '0; lx_fill = '0;
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) tokens_due.push_back(found[i]);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("dfa_longest_match_lexer test failed");
            $finish;
        end
    end

    // token side: random stalls, check each transfer
    int stall_left;
    int stall_draw;
    always @(posedge i_clk) begin
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            if (tokens_due.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10) $display("unexpected token kind %0d start %0d",
                    tok_if.token_kind, tok_if.token_start);
            end else begin
                if ({tok_if.token_kind, tok_if.token_start, tok_if.token_length,
                     tok_if.last_of_step} !== tokens_due[0]) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("token mismatch exp k%0d s%0d l%0d e%0d got k%0d s%0d l%0d e%0d",
                            tokens_due[0].kind, tokens_due[0].start, tokens_due[0].length,
                            tokens_due[0].last, tok_if.token_kind, tok_if.token_start,
                            tok_if.token_length, tok_if.last_of_step);
                end
                void'(tokens_due.pop_front());
            end
        end
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            tok_if.ready  <= 1'b0;
        end else if (tok_if.valid && tok_if.ready) begin
            stall_draw = (cycle_cnt % 4000 < 1000) ? 0 : $urandom_range(0, 6);
            if (stall_draw == 0) begin
                tok_if.ready <= 1'b1;
            end else begin
                stall_left   <= stall_draw - 1;
                tok_if.ready <= 1'b0;
            end
        end else begin
            tok_if.ready  <= 1'b1;
        end
    end

    task automatic send_char(logic [7:0] c, logic eol);
        int gap;
        chr_if.valid     <= 1'b1;
        chr_if.char_code <= c;
        chr_if.line_end  <= eol;
        do @(posedge i_clk); while (!chr_if.ready);
        lex_char(c, eol);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            chr_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(string s, logic eol);
        for (int i = 0; i < s.len(); i++) send_char(s[i], eol && i == s.len() - 1);
    endtask

    task automatic test_token_kinds();
        send_text("if iff x9 12 12.5b .p3 .5 --ab\n", 1'b1);
        send_text("a- -x ## \n  if", 1'b1);
    endtask

    task automatic test_special_bytes();
        send_char(8'd0, 1'b0);
        send_char(8'd255, 1'b0);
        send_char(8'd128, 1'b0);
        send_char(CHAR_NL, 1'b0);
        send_char(8'd127, 1'b1);
        send_char(8'd122, 1'b1);
    endtask

    task automatic test_random_lines();
        string pieces [12] = '{"if", "ab9", "123", "4.5c", ".p7", "--xy\n", " ", "  ",
                               "-", "\n", "9.", "i"};
        int sent;
        int cnt;
        sent = 0;
        while (sent < 400) begin
            cnt = $urandom_range(1, 12);
            for (int p = 0; p < cnt; p++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_char(8'($urandom), 1'b0);
                    sent++;
                end else begin
                    string s;
                    s = pieces[$urandom_range(0, 11)];
                    send_text(s, 1'b0);
                    sent += s.len();
                end
            end
            send_char(($urandom_range(0, 1) == 1) ? 8'd32 : 8'($urandom), 1'b1);
            sent++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        chr_if.valid     = 1'b0;
        chr_if.char_code = '0;
        chr_if.line_end  = 1'b0;
        tok_if.ready     = 1'b0;
        stall_left       = 0;
        stall_draw       = 0;
        mismatch_cnt     = 0;
        cycle_cnt        = 0;
        lx_state = ST_START;
        lx_begin = '0; lx_acc_len = '0; lx_acc_state = ST_DEAD; lx_pos = '0; lx_fill = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_token_kinds();
        test_special_bytes();
        test_random_lines();
        chr_if.valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0 && tokens_due.size() == 0) begin
            $display("dfa_longest_match_lexer test passed");
        end else begin
            $display("dfa_longest_match_lexer test failed");
        end
        $finish;
    end
endmodule

@@ dfa_longest_match_lexer.f @@
rtl/dfalex_pkg.sv
rtl/dfalex_if.sv
rtl/dfalex_ram.sv
rtl/dfa_longest_match_lexer.sv
sim/dfalex_tb_if.sv
sim/testbench.sv
